/* rtl/core/b64d_pkg.sv */
package b64d_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_BAD_PAD  = 2'd2;
	localparam logic [1:0] ST_BAD_LEN  = 2'd3;

	// Job queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	// Input word: one character
	typedef struct packed {
		logic [7:0] symbol_char;
		logic       last_symbol;
	} sym_word_t;

	// Output word: one decoded byte or status
	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] status;
		logic       last_of_run;
		logic       end_of_frame;
	} byte_word_t;

	// Job from front to back: up to three bytes, first byte in the high bits
	typedef struct packed {
		logic [23:0] data;
		logic [1:0]  last_idx;
		logic [1:0]  status;
		logic        eof;
	} b64d_job_t;

endpackage

/* rtl/core/base64url_strict_decoder.sv */
// Channel  | Handshake     | Word
// ---------+---------------+------------------------------------------------
// symbol   | push / full   | symbol_char, last_symbol (one character)
// result   | pop / empty   | data_byte, status, last_of_run, end_of_frame
//
// A character is classified in the cycle it is taken and its job enters the
// four-entry queue at that edge; its first word shows once the back end loads
// it. Input takes one character per cycle unless full and the back end sends
// one word per cycle while pop is held, so a group of four gives three words;
// full rises only when the queue is full. Reset clears group state, queue
// and output stage. A pop stall backs up via the queue to full, losing no words.
module base64url_strict_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  b64d_pkg::sym_word_t  symbol,
	input  logic                 pop,
	output logic                 empty,
	output b64d_pkg::byte_word_t result
);
	import b64d_pkg::*;

	logic      accept;
	logic      job_valid;
	b64d_job_t job;
	logic      q_rd;
	logic      q_empty;
	b64d_job_t q_data;

	assign accept = push && !full;

	// Decode and classify
	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sym       (symbol),
		.job_valid (job_valid),
		.job       (job)
	);

	// Job queue
	b64d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && job_valid),
		.wr_data (job),
		.full    (full),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// Byte output
	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

/* rtl/core/b64d_front.sv */
module b64d_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  b64d_pkg::sym_word_t sym,
	output logic               job_valid,
	output b64d_pkg::b64d_job_t job
);
	import b64d_pkg::*;

	logic [1:0]  phase_q;
	logic [17:0] acc_q;
	logic        discard_q;

	logic [1:0]  phase_d;
	logic [17:0] acc_d;
	logic        discard_d;

	logic        sym_ok;
	logic [5:0]  sym_val;
	logic [17:0] acc_n;
	logic [1:0]  n_cnt;
	logic [7:0]  ch;

	// Alphabet lookup: A-Z, a-z, 0-9, '-', '_'
	always_comb begin
		ch = sym.symbol_char;
		sym_ok = 1'b1;
		sym_val = 6'd0;
		if (ch >= "A" && ch <= "Z") begin
			sym_val = 6'(ch - 8'd65);
		end else if (ch >= "a" && ch <= "z") begin
			sym_val = 6'(ch - 8'd97 + 8'd26);
		end else if (ch >= "0" && ch <= "9") begin
			sym_val = 6'(ch - 8'd48 + 8'd52);
		end else if (ch == "-") begin
			sym_val = 6'd62;
		end else if (ch == "_") begin
			sym_val = 6'd63;
		end else begin
			sym_ok = 1'b0;
		end
	end

	assign acc_n = {acc_q[11:0], sym_val};
	assign n_cnt = phase_q + 2'd1;

	// Classify the character and build a job
	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		discard_d = discard_q;
		job_valid = 1'b0;
		job       = '{data: 24'd0, last_idx: 2'd0, status: ST_OK, eof: 1'b1};
		priority if (discard_q) begin
			if (sym.last_symbol) begin
				discard_d = 1'b0;
				phase_d   = 2'd0;
				acc_d     = 18'd0;
			end
		end else if (!sym_ok) begin
			phase_d    = 2'd0;
			acc_d      = 18'd0;
			discard_d  = !sym.last_symbol;
			job_valid  = 1'b1;
			job.status = ST_BAD_CHAR;
		end else if (phase_q == 2'd3) begin
			phase_d      = 2'd0;
			acc_d        = 18'd0;
			job_valid    = 1'b1;
			job.data     = {acc_q, sym_val};
			job.last_idx = 2'd2;
			job.eof      = sym.last_symbol;
		end else if (!sym.last_symbol) begin
			phase_d = n_cnt;
			acc_d   = acc_n;
		end else begin
			// Tail at end of string
			phase_d   = 2'd0;
			acc_d     = 18'd0;
			job_valid = 1'b1;
			priority if (n_cnt == 2'd1) begin
				job.status = ST_BAD_LEN;
			end else if (n_cnt == 2'd2) begin
				if (sym_val[3:0] != 4'd0) begin
					job.status = ST_BAD_PAD;
				end else begin
					job.data = {acc_n[11:4], 16'd0};
				end
			end else begin
				if (sym_val[1:0] != 2'd0) begin
					job.status = ST_BAD_PAD;
				end else begin
					job.data     = {acc_n[17:10], acc_n[9:2], 8'd0};
					job.last_idx = 2'd1;
				end
			end
		end
	end

	// Group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			acc_q     <= 18'd0;
			discard_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			acc_q     <= acc_d;
			discard_q <= discard_d;
		end
	end

endmodule

/* rtl/core/b64d_queue.sv */
module b64d_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  b64d_pkg::b64d_job_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output b64d_pkg::b64d_job_t rd_data,
	output logic               empty
);
	import b64d_pkg::*;

	b64d_job_t      mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = (count_q == (QAW+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/b64d_back.sv */
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  b64d_pkg::b64d_job_t  q_data,
	output logic                q_rd,
	input  logic                pop,
	output logic                empty,
	output b64d_pkg::byte_word_t result
);
	import b64d_pkg::*;

	b64d_job_t  job_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       at_last;
	logic       taken;

	assign at_last = (idx_q == job_q.last_idx);
	assign taken   = pop && valid_q;
	assign q_rd    = !q_empty && (!valid_q || (taken && at_last));
	assign empty   = !valid_q;

	// Byte select for the current word
	always_comb begin
		unique case (idx_q)
			2'd0:    result.data_byte = job_q.data[23:16];
			2'd1:    result.data_byte = job_q.data[15:8];
			default: result.data_byte = job_q.data[7:0];
		endcase
		result.status       = job_q.status;
		result.last_of_run  = at_last;
		result.end_of_frame = at_last && job_q.eof;
	end

	// Current job and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (taken) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			job_q <= q_data;
		end
	end

endmodule
